@@ hw/rtl/nge_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the noise gate envelope block.
// Used by every module and interface under hw/rtl except nge_queue; depends on nothing else.
package nge_pkg;

    // Frame shape and fixed-point formats.
    localparam int CHANNELS        = 2;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int THRESH_BITS     = 24;
    localparam int COEF_BITS       = 17;
    localparam int FRAC_BITS       = 16;
    localparam int CH_BITS         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [COEF_BITS-1:0] ONE_Q16 = COEF_BITS'(1 << FRAC_BITS);

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GATE_ENABLE = 3'd0,
        REG_THRESHOLD   = 3'd1,
        REG_ATTACK      = 3'd2,
        REG_RELEASE     = 3'd3,
        REG_OPEN_GAIN   = 3'd4,
        REG_CLOSED_GAIN = 3'd5
    } cfg_index_t;

    // Register contents as the datapath sees them, coefficients and gains clamped to one.
    typedef struct packed {
        logic                   gate_enable;
        logic [THRESH_BITS-1:0] threshold_level;
        logic [COEF_BITS-1:0]   attack_coef;
        logic [COEF_BITS-1:0]   release_coef;
        logic [COEF_BITS-1:0]   open_gain;
        logic [COEF_BITS-1:0]   closed_gain;
    } cfg_t;

    // Sequencer of the back end.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV_MUL,
        ST_ENV_ADD,
        ST_GAIN_MUL,
        ST_GAIN_ADD,
        ST_CHAN
    } back_state_t;

    // Limit a Q1.16 value to unity.
    function automatic logic [COEF_BITS-1:0] clamp_one(input logic [COEF_BITS-1:0] v);
        clamp_one = (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

@@ hw/rtl/nge_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: audio frames in, gated frames out, register writes.
// Widths come from nge_pkg.
interface nge_in_if #(
    parameter int SAMPLE_BITS = nge_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_zero;
    logic signed [SAMPLE_BITS-1:0] sample_one;

    modport source (output valid, output sample_zero, output sample_one, input ready);
    modport sink   (input valid, input sample_zero, input sample_one, output ready);
endinterface

interface nge_out_if #(
    parameter int SAMPLE_BITS = nge_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] gated_zero;
    logic signed [SAMPLE_BITS-1:0] gated_one;

    modport source (output valid, output gated_zero, output gated_one, input ready);
    modport sink   (input valid, input gated_zero, input gated_one, output ready);
endinterface

interface nge_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [nge_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [nge_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/nge_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file of the noise gate.
// Depends on nge_pkg and nge_cfg_if.
module nge_regs (
    input  logic          clk,
    input  logic          rst_n,
    nge_cfg_if.sink       cfg,
    output nge_pkg::cfg_t cfg_val
);

    logic                            enable_reg;
    logic [nge_pkg::THRESH_BITS-1:0] threshold_reg;
    logic [nge_pkg::COEF_BITS-1:0]   attack_reg;
    logic [nge_pkg::COEF_BITS-1:0]   release_reg;
    logic [nge_pkg::COEF_BITS-1:0]   open_reg;
    logic [nge_pkg::COEF_BITS-1:0]   closed_reg;
    logic                            wr_en;

    // Writes are always taken.
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    // Register writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            threshold_reg <= '0;
            attack_reg    <= nge_pkg::ONE_Q16;
            release_reg   <= nge_pkg::ONE_Q16;
            open_reg      <= nge_pkg::ONE_Q16;
            closed_reg    <= '0;
        end
        else if (wr_en)
        begin
            unique case (nge_pkg::cfg_index_t'(cfg.index))
                nge_pkg::REG_GATE_ENABLE: enable_reg    <= cfg.data[0];
                nge_pkg::REG_THRESHOLD:   threshold_reg <= cfg.data[nge_pkg::THRESH_BITS-1:0];
                nge_pkg::REG_ATTACK:      attack_reg    <= cfg.data[nge_pkg::COEF_BITS-1:0];
                nge_pkg::REG_RELEASE:     release_reg   <= cfg.data[nge_pkg::COEF_BITS-1:0];
                nge_pkg::REG_OPEN_GAIN:   open_reg      <= cfg.data[nge_pkg::COEF_BITS-1:0];
                nge_pkg::REG_CLOSED_GAIN: closed_reg    <= cfg.data[nge_pkg::COEF_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Present clamped values so the datapath never sees a gain above one.
    always_comb
    begin
        cfg_val.gate_enable     = enable_reg;
        cfg_val.threshold_level = threshold_reg;
        cfg_val.attack_coef     = nge_pkg::clamp_one(attack_reg);
        cfg_val.release_coef    = nge_pkg::clamp_one(release_reg);
        cfg_val.open_gain       = nge_pkg::clamp_one(open_reg);
        cfg_val.closed_gain     = nge_pkg::clamp_one(closed_reg);
    end

endmodule

@@ hw/rtl/nge_front.sv @@
`timescale 1ns / 1ps
// Front end: takes audio frames, finds the peak magnitude and tags pass-through frames.
// Depends on nge_pkg and nge_in_if.
module nge_front #(
    parameter int SAMPLE_BITS = nge_pkg::SAMPLE_BITS_DEF,
    parameter int ENTRY_BITS  = 1 + (nge_pkg::CHANNELS + 1) * SAMPLE_BITS
) (
    nge_in_if.sink           audio,
    input  logic             gate_enable,
    output logic             push_valid,
    input  logic             push_ready,
    output logic [ENTRY_BITS-1:0] push_data
);

    logic [nge_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] samples;
    logic [nge_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] mags;
    logic [SAMPLE_BITS-1:0]                        det;

    assign samples[0] = audio.sample_zero;
    assign samples[1] = audio.sample_one;

    // Magnitudes; full-scale negative comes out as 2^(SAMPLE_BITS-1), read as unsigned.
    always_comb
    begin
        for (int c = 0; c < nge_pkg::CHANNELS; c++)
        begin
            mags[c] = samples[c][SAMPLE_BITS-1] ? (~samples[c] + 1'b1) : samples[c];
        end
    end

    // Detector is the largest magnitude across channels.
    always_comb
    begin
        det = '0;
        for (int c = 0; c < nge_pkg::CHANNELS; c++)
        begin
            if (mags[c] > det)
            begin
                det = mags[c];
            end
        end
    end

    // Queue entry: pass-through tag, detector, raw samples.
    assign push_data   = {~gate_enable, det, samples};
    assign push_valid  = audio.valid;
    assign audio.ready = push_ready;

endmodule

@@ hw/rtl/nge_queue.sv @@
`timescale 1ns / 1ps
// Small first-in first-out queue between the front and back ends.
// Register based; depends on no other file.
module nge_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/nge_back.sv @@
`timescale 1ns / 1ps
// Back end: envelope follower, gain smoother and channel scaling on one shared multiplier.
// Depends on nge_pkg and nge_out_if.
module nge_back #(
    parameter int SAMPLE_BITS = nge_pkg::SAMPLE_BITS_DEF,
    parameter int ENTRY_BITS  = 1 + (nge_pkg::CHANNELS + 1) * SAMPLE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nge_pkg::cfg_t         cfg_val,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  logic [ENTRY_BITS-1:0] pop_data,
    nge_out_if.source             gated
);

    localparam int CHN      = nge_pkg::CHANNELS;
    localparam int CB       = nge_pkg::CH_BITS;
    localparam int A_BITS   = SAMPLE_BITS + 2;
    localparam int B_BITS   = nge_pkg::COEF_BITS + 1;
    localparam int P_BITS   = A_BITS + B_BITS;
    localparam int CMP_BITS = (SAMPLE_BITS > nge_pkg::THRESH_BITS) ? SAMPLE_BITS
                                                                   : nge_pkg::THRESH_BITS;

    nge_pkg::back_state_t state_reg, state_next;

    logic [CB-1:0]                       chan_reg, chan_next;
    logic [SAMPLE_BITS-1:0]              env_reg, env_next;
    logic [nge_pkg::COEF_BITS-1:0]       gain_reg, gain_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                bypass_reg;
    logic [SAMPLE_BITS-1:0]              det_reg;
    logic [CHN-1:0][SAMPLE_BITS-1:0]     samp_reg, res_reg, out_reg, out_next;
    logic signed [P_BITS-1:0]            prod_reg;

    // Sequencer controls.
    logic take_item, prod_load, env_load, gain_load, lane_load, out_load;
    logic last_chan, out_free;

    // Datapath wires.
    logic signed [A_BITS-1:0]            mul_a;
    logic signed [B_BITS-1:0]            mul_b;
    logic signed [P_BITS-1:0]            product;
    logic signed [P_BITS-1:0]            prod_shift, lane_shift;
    logic signed [A_BITS-1:0]            env_diff, env_sum;
    logic signed [B_BITS-1:0]            gain_diff;
    logic [B_BITS-1:0]                   gain_sum;
    logic [nge_pkg::COEF_BITS-1:0]       target;
    logic [nge_pkg::COEF_BITS-1:0]       env_coef, gain_coef;
    logic [SAMPLE_BITS-1:0]              lane;

    assign last_chan = (chan_reg == CB'(CHN - 1));
    assign out_free  = !out_valid_reg || gated.ready;

    // Envelope step operands: coefficient by direction of the detector.
    assign env_diff = $signed({2'b00, det_reg}) - $signed({2'b00, env_reg});
    assign env_coef = (det_reg > env_reg) ? cfg_val.attack_coef : cfg_val.release_coef;

    // Gain target from the updated envelope, then the smoothing step operands.
    assign target    = (CMP_BITS'(env_reg) >= CMP_BITS'(cfg_val.threshold_level))
                       ? cfg_val.open_gain : cfg_val.closed_gain;
    assign gain_diff = $signed({1'b0, target}) - $signed({1'b0, gain_reg});
    assign gain_coef = (target > gain_reg) ? cfg_val.attack_coef : cfg_val.release_coef;

    // Shared multiplier; shifts round toward minus infinity.
    assign product    = mul_a * mul_b;
    assign prod_shift = prod_reg >>> nge_pkg::FRAC_BITS;
    assign lane_shift = product >>> nge_pkg::FRAC_BITS;

    assign env_sum  = $signed({2'b00, env_reg}) + $signed(prod_shift[A_BITS-1:0]);
    assign gain_sum = {1'b0, gain_reg} + prod_shift[B_BITS-1:0];
    assign lane     = bypass_reg ? samp_reg[chan_reg] : lane_shift[SAMPLE_BITS-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nge_pkg::ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = pop_data[ENTRY_BITS-1] ? nge_pkg::ST_CHAN : nge_pkg::ST_ENV_MUL;
                end
            end
            nge_pkg::ST_ENV_MUL:  state_next = nge_pkg::ST_ENV_ADD;
            nge_pkg::ST_ENV_ADD:  state_next = nge_pkg::ST_GAIN_MUL;
            nge_pkg::ST_GAIN_MUL: state_next = nge_pkg::ST_GAIN_ADD;
            nge_pkg::ST_GAIN_ADD: state_next = nge_pkg::ST_CHAN;
            nge_pkg::ST_CHAN:
            begin
                if (last_chan && out_free)
                begin
                    state_next = nge_pkg::ST_IDLE;
                end
            end
            default:              state_next = nge_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs and multiplier operand selection.
    always_comb
    begin
        pop_ready = 1'b0;
        take_item = 1'b0;
        prod_load = 1'b0;
        env_load  = 1'b0;
        gain_load = 1'b0;
        lane_load = 1'b0;
        out_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            nge_pkg::ST_IDLE:
            begin
                pop_ready = 1'b1;
                take_item = pop_valid;
            end
            nge_pkg::ST_ENV_MUL:
            begin
                mul_a     = env_diff;
                mul_b     = $signed({1'b0, env_coef});
                prod_load = 1'b1;
            end
            nge_pkg::ST_ENV_ADD:
            begin
                env_load = 1'b1;
            end
            nge_pkg::ST_GAIN_MUL:
            begin
                mul_a     = A_BITS'(gain_diff);
                mul_b     = $signed({1'b0, gain_coef});
                prod_load = 1'b1;
            end
            nge_pkg::ST_GAIN_ADD:
            begin
                gain_load = 1'b1;
            end
            nge_pkg::ST_CHAN:
            begin
                mul_a     = A_BITS'($signed(samp_reg[chan_reg]));
                mul_b     = $signed({1'b0, gain_reg});
                lane_load = 1'b1;
                out_load  = last_chan && out_free;
            end
            default:
            begin
            end
        endcase
    end

    // State register updates.
    always_comb
    begin
        chan_next = chan_reg;
        if (take_item)
        begin
            chan_next = '0;
        end
        else if (lane_load && !last_chan)
        begin
            chan_next = chan_reg + 1'b1;
        end
        env_next  = env_load  ? env_sum[SAMPLE_BITS-1:0] : env_reg;
        gain_next = gain_load ? gain_sum[nge_pkg::COEF_BITS-1:0] : gain_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !gated.ready;
        end
    end

    // Output payload: finished lanes plus the one produced this cycle.
    always_comb
    begin
        for (int c = 0; c < CHN; c++)
        begin
            out_next[c] = (CB'(c) == chan_reg) ? lane : res_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nge_pkg::ST_IDLE;
            chan_reg      <= '0;
            env_reg       <= '0;
            gain_reg      <= nge_pkg::ONE_Q16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            env_reg       <= env_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            bypass_reg <= pop_data[ENTRY_BITS-1];
            det_reg    <= pop_data[CHN*SAMPLE_BITS +: SAMPLE_BITS];
            samp_reg   <= pop_data[CHN*SAMPLE_BITS-1:0];
        end
        if (prod_load)
        begin
            prod_reg <= product;
        end
        if (lane_load)
        begin
            res_reg[chan_reg] <= lane;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign gated.valid      = out_valid_reg;
    assign gated.gated_zero = out_reg[0];
    assign gated.gated_one  = out_reg[1];

endmodule

@@ hw/rtl/noise_gate_envelope_top.sv @@
`timescale 1ns / 1ps
// Top level of the audio noise gate with envelope follower.
// Depends on nge_pkg, nge_if, nge_regs, nge_front, nge_queue and nge_back.
//
//   Port    Direction  Transfer carries
//   audio   in         one frame: sample_zero, sample_one (signed)
//   gated   out        one frame: gated_zero, gated_one (signed)
//   cfg     in         register index and write data
//
// A gated frame is taken from the queue, then the envelope and the gain are each updated
// on the shared multiplier by a multiply step and an add step, and then each channel is
// scaled. A pass-through frame skips those updates. The shared multiplier sets the rate.
// Reset clears the envelope to zero and sets the gain to unity; registers take defaults.
// The two-entry queue keeps the input taking frames while the back end works, and the
// output register lets a result wait while the next frame is being processed.
module noise_gate_envelope_top #(
    parameter int SAMPLE_BITS = nge_pkg::SAMPLE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    nge_in_if.sink    audio,
    nge_out_if.source gated,
    nge_cfg_if.sink   cfg
);

    localparam int ENTRY_BITS = 1 + (nge_pkg::CHANNELS + 1) * SAMPLE_BITS;

    nge_pkg::cfg_t         cfg_val;
    logic                  push_valid, push_ready;
    logic [ENTRY_BITS-1:0] push_data;
    logic                  pop_valid, pop_ready;
    logic [ENTRY_BITS-1:0] pop_data;

    nge_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    nge_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_front (
        .audio       (audio),
        .gate_enable (cfg_val.gate_enable),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    nge_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (nge_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    nge_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_val   (cfg_val),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .gated     (gated)
    );

    // The back end is still busy with a frame right after taking it, so it never takes two back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> !pop_ready)
        else $error("back end took two frames in consecutive cycles");

    // After a push into the queue, the queue is not empty on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready) |=> pop_valid)
        else $error("queue lost a pushed frame");

    // The queue only fills up as a result of a push.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(push_ready) |-> $past(push_valid))
        else $error("queue became full without a push");

endmodule

@@ tb/noise_gate_envelope_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for noise_gate_envelope_top: random and directed audio frames,
// register writes between phases, and a scoreboard that predicts every gated frame.
// Depends on nge_pkg, the channel interfaces in nge_if and the RTL under hw/rtl.

localparam int     SAMPLE_W = nge_pkg::SAMPLE_BITS_DEF;
localparam longint UNITY    = longint'(nge_pkg::ONE_Q16);

typedef struct packed {
    logic signed [SAMPLE_W-1:0] zero;
    logic signed [SAMPLE_W-1:0] one;
} audio_frame_t;

// Gate predictor: shadow registers, envelope and gain state, and the gated frames still due.
class gate_scoreboard;
    logic                            gate_on;
    logic [nge_pkg::THRESH_BITS-1:0] open_level;
    logic [nge_pkg::COEF_BITS-1:0]   rise_coef;
    logic [nge_pkg::COEF_BITS-1:0]   fall_coef;
    logic [nge_pkg::COEF_BITS-1:0]   open_target;
    logic [nge_pkg::COEF_BITS-1:0]   closed_target;
    longint                          envelope;
    longint                          gain;
    audio_frame_t                    gated_due[$];
    int                              failures;

    function new();
        gate_on       = 1'b0;
        open_level    = '0;
        rise_coef     = nge_pkg::ONE_Q16;
        fall_coef     = nge_pkg::ONE_Q16;
        open_target   = nge_pkg::ONE_Q16;
        closed_target = '0;
        envelope      = 0;
        gain          = UNITY;
        failures      = 0;
    endfunction

    function int pending();
        return gated_due.size();
    endfunction

    // Coefficients and gains above one are treated as exactly one.
    function longint capped(logic [nge_pkg::COEF_BITS-1:0] v);
        return (v > nge_pkg::ONE_Q16) ? UNITY : longint'(v);
    endfunction

    function longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // One-pole step towards x; the arithmetic shift rounds towards minus infinity.
    function longint glide(longint y, longint x, longint c);
        return y + ((c * (x - y)) >>> nge_pkg::FRAC_BITS);
    endfunction

    // Register write as seen at the configuration port; unmapped indexes change nothing.
    function void set_register(logic [nge_pkg::CFG_INDEX_BITS-1:0] idx,
                               logic [nge_pkg::CFG_DATA_BITS-1:0] value);
        case (nge_pkg::cfg_index_t'(idx))
            nge_pkg::REG_GATE_ENABLE: gate_on       = value[0];
            nge_pkg::REG_THRESHOLD:   open_level    = value[nge_pkg::THRESH_BITS-1:0];
            nge_pkg::REG_ATTACK:      rise_coef     = value[nge_pkg::COEF_BITS-1:0];
            nge_pkg::REG_RELEASE:     fall_coef     = value[nge_pkg::COEF_BITS-1:0];
            nge_pkg::REG_OPEN_GAIN:   open_target   = value[nge_pkg::COEF_BITS-1:0];
            nge_pkg::REG_CLOSED_GAIN: closed_target = value[nge_pkg::COEF_BITS-1:0];
            default: ;
        endcase
    endfunction

    // An accepted input frame yields one gated frame; with the gate enabled it also moves the envelope and gain.
    function void take_frame(logic signed [SAMPLE_W-1:0] zero, logic signed [SAMPLE_W-1:0] one);
        longint       s0;
        longint       s1;
        longint       det;
        longint       rise;
        longint       fall;
        longint       target;
        audio_frame_t due;
        s0  = zero;
        s1  = one;
        det = magnitude(s0);
        if (magnitude(s1) > det)
            det = magnitude(s1);
        if (!gate_on)
        begin
            due.zero = zero;
            due.one  = one;
        end
        else
        begin
            rise     = capped(rise_coef);
            fall     = capped(fall_coef);
            envelope = glide(envelope, det, (det > envelope) ? rise : fall);
            target   = (envelope >= longint'(open_level)) ? capped(open_target)
                                                          : capped(closed_target);
            gain     = glide(gain, target, (target > gain) ? rise : fall);
            due.zero = SAMPLE_W'((s0 * gain) >>> nge_pkg::FRAC_BITS);
            due.one  = SAMPLE_W'((s1 * gain) >>> nge_pkg::FRAC_BITS);
        end
        gated_due.push_back(due);
    endfunction

    // Compare a gated frame with the oldest one due.
    function void check_frame(logic signed [SAMPLE_W-1:0] zero,
                              logic signed [SAMPLE_W-1:0] one);
        audio_frame_t due;
        if (gated_due.size() == 0)
        begin
            $display("%0t: gated frame with none due: zero %0d one %0d", $time, zero, one);
            failures++;
            return;
        end
        due = gated_due.pop_front();
        if (zero !== due.zero)
        begin
            $display("%0t: gated_zero expected %0d, got %0d", $time, due.zero, zero);
            failures++;
        end
        if (one !== due.one)
        begin
            $display("%0t: gated_one expected %0d, got %0d", $time, due.one, one);
            failures++;
        end
    endfunction
endclass

module noise_gate_envelope_top_test;

    localparam int    PHASES           = 10;
    localparam int    FRAMES_PER_PHASE = 140;
    localparam int    CYCLE_LIMIT      = 400000;
    localparam int    FULL_POS         = 8388607;
    localparam int    FULL_NEG         = -8388608;
    // Indexes that no register answers to.
    localparam logic [nge_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [nge_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   cycles    = 0;
    int   phase;

    gate_scoreboard sb = new();

    nge_in_if #(.SAMPLE_BITS(SAMPLE_W))  audio_ch ();
    nge_out_if #(.SAMPLE_BITS(SAMPLE_W)) gated_ch ();
    nge_cfg_if                           cfg_ch ();

    noise_gate_envelope_top #(.SAMPLE_BITS(SAMPLE_W)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .audio (audio_ch),
        .gated (gated_ch),
        .cfg   (cfg_ch)
    );

    // Clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Transfers are observed at the rising edge on all three channels.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (gated_ch.valid && gated_ch.ready)
                sb.check_frame(gated_ch.gated_zero, gated_ch.gated_one);
            if (audio_ch.valid && audio_ch.ready)
                sb.take_frame(audio_ch.sample_zero, audio_ch.sample_one);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_register(cfg_ch.index, cfg_ch.data);
        end
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge clk)
    begin
        gated_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Phases cycle through: no idling, sender idle, receiver stalling, both lightly.
    task automatic set_pressure(input int p);
        case (p % 4)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 47;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 47;
            end
            default:
            begin
                idle_pct  = 6;
                stall_pct = 6;
            end
        endcase
    endtask

    // Offer one frame from a falling edge and return at the falling edge after its transfer.
    // Valid is left high so that a following frame goes out back to back.
    task automatic send_frame(input int a, input int b);
        while ($urandom_range(99) < idle_pct)
        begin
            audio_ch.valid <= 1'b0;
            @(negedge clk);
        end
        audio_ch.valid       <= 1'b1;
        audio_ch.sample_zero <= SAMPLE_W'(a);
        audio_ch.sample_one  <= SAMPLE_W'(b);
        do @(posedge clk); while (!audio_ch.ready);
        @(negedge clk);
    endtask

    // Stop offering frames and wait until every gated frame has been taken.
    task automatic settle();
        audio_ch.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(input logic [nge_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [nge_pkg::CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    // Write all six registers, then optionally an unmapped index, while the block is idle.
    task automatic configure(input logic [nge_pkg::CFG_DATA_BITS-1:0] en,
                             input logic [nge_pkg::CFG_DATA_BITS-1:0] thr,
                             input logic [nge_pkg::CFG_DATA_BITS-1:0] rise,
                             input logic [nge_pkg::CFG_DATA_BITS-1:0] fall,
                             input logic [nge_pkg::CFG_DATA_BITS-1:0] open_g,
                             input logic [nge_pkg::CFG_DATA_BITS-1:0] closed_g,
                             input bit poke_spare);
        cfg_write(nge_pkg::REG_GATE_ENABLE, en);
        cfg_write(nge_pkg::REG_THRESHOLD, thr);
        cfg_write(nge_pkg::REG_ATTACK, rise);
        cfg_write(nge_pkg::REG_RELEASE, fall);
        cfg_write(nge_pkg::REG_OPEN_GAIN, open_g);
        cfg_write(nge_pkg::REG_CLOSED_GAIN, closed_g);
        if (poke_spare)
            cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 24'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Smoothing coefficient: zero, tiny, unity, above one with junk upper bits, or typical.
    function automatic logic [nge_pkg::CFG_DATA_BITS-1:0] pick_coef();
        logic [nge_pkg::CFG_DATA_BITS-1:0] w;
        case ($urandom_range(5))
            0: w = 24'd0;
            1: w = 24'd1;
            2: w = 24'd65536;
            3:
            begin
                w     = 24'($urandom);
                w[16] = 1'b1;
            end
            default: w = 24'($urandom_range(1 << $urandom_range(16, 4), 1));
        endcase
        return w;
    endfunction

    function automatic logic [nge_pkg::CFG_DATA_BITS-1:0] pick_gain();
        logic [nge_pkg::CFG_DATA_BITS-1:0] w;
        case ($urandom_range(4))
            0: w = 24'd0;
            1: w = 24'd65536;
            2:
            begin
                w     = 24'($urandom);
                w[16] = 1'b1;
            end
            default: w = 24'($urandom_range(65536));
        endcase
        return w;
    endfunction

    // Audio-like stimulus: bursts at one loudness, from silence to full scale, with some
    // full-range noise and full-scale extremes mixed in.
    task automatic random_frames(input int count);
        int left;
        int burst;
        int amp_bits;
        int a;
        int b;
        int k;
        left = count;
        while (left > 0)
        begin
            burst    = $urandom_range(24, 4);
            amp_bits = $urandom_range(23, 0);
            for (k = 0; k < burst && left > 0; k++)
            begin
                case ($urandom_range(99))
                    0, 1, 2, 3, 4, 5, 6, 7:
                    begin
                        a = int'($urandom);
                        b = int'($urandom);
                    end
                    8, 9, 10:
                    begin
                        a = $urandom_range(1) ? FULL_NEG : FULL_POS;
                        b = $urandom_range(1) ? -1 : 0;
                    end
                    default:
                    begin
                        a = int'($urandom & ((32'd1 << amp_bits) - 1));
                        b = int'($urandom & ((32'd1 << amp_bits) - 1));
                        if ($urandom_range(1))
                            a = -a;
                        if ($urandom_range(1))
                            b = -b;
                    end
                endcase
                send_frame(a, b);
                left--;
            end
        end
    endtask

    initial
    begin
        logic [nge_pkg::CFG_DATA_BITS-1:0] en_word;
        logic [nge_pkg::CFG_DATA_BITS-1:0] level;

        rst_n                = 1'b0;
        audio_ch.valid       = 1'b0;
        audio_ch.sample_zero = '0;
        audio_ch.sample_one  = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset leaves the gate disabled: frames pass through untouched.
        send_frame(FULL_POS, FULL_NEG);
        send_frame(FULL_NEG, FULL_POS);
        send_frame(0, -1);
        settle();

        // Instant coefficients: the gate opens exactly at the threshold.
        configure(24'd1, 24'h400000, 24'd65536, 24'd65536, 24'd65536, 24'd0, 1'b0);
        send_frame(FULL_NEG, 0);
        send_frame(24'h400000, -24'h3FFFFF);
        send_frame(24'h3FFFFF, 5);
        send_frame(24'h400000, 0);
        settle();

        // Coefficients and gains above one are held at one; negative products round down.
        configure(24'd1, 24'h100000, 24'h01FFFF, 24'h010001, 24'h01FFFF, 24'h008000, 1'b0);
        send_frame(-1, 1);
        send_frame(-3, FULL_POS);
        send_frame(-5, -7);
        settle();

        // Slow attack and release, loud then quiet.
        configure(24'd1, 24'h020000, 24'h001000, 24'h000100, 24'h00C000, 24'h000800, 1'b0);
        send_frame(FULL_POS, -FULL_POS);
        send_frame(24'h600000, 24'h012345);
        send_frame(-FULL_POS, 0);
        send_frame(16, -16);
        send_frame(16, 16);
        send_frame(0, 0);
        settle();

        // Zero coefficients freeze the envelope and the gain.
        configure(24'd1, 24'h020000, 24'd0, 24'd0, 24'h00C000, 24'h000800, 1'b0);
        send_frame(FULL_POS, 0);
        send_frame(1, 1);
        settle();

        // Upper data bits are dropped, so this enable word disables the gate; spare index too.
        configure(24'hFFFFFE, 24'hFFFFFF, 24'h3FFFFF, 24'hFE8000, 24'hFF0000, 24'hFFFFFF, 1'b1);
        send_frame(24'h5A5A5A, -24'h5A5A5A);
        send_frame(FULL_NEG, FULL_NEG);
        settle();

        // Enabled again, but the threshold sits above any envelope the samples can give.
        configure(24'hFFFFFF, 24'hFFFFFF, 24'h3FFFFF, 24'hFE8000, 24'hFF0000, 24'hFF4000, 1'b1);
        send_frame(24'h123456, -24'h654321);
        send_frame(FULL_NEG, FULL_POS);

        // Random phases, each with fresh register contents and one of the four idling patterns in turn.
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            set_pressure(phase);
            en_word    = 24'($urandom);
            en_word[0] = ($urandom_range(9) != 0);
            case ($urandom_range(5))
                0: level = 24'd0;
                1: level = 24'h800000;
                2: level = 24'hFFFFFF;
                default: level = 24'($urandom_range(1 << $urandom_range(23)));
            endcase
            configure(en_word, level, pick_coef(), pick_coef(), pick_gain(), pick_gain(),
                      $urandom_range(3) == 0);
            random_frames(FRAMES_PER_PHASE);
        end

        // Drain, allow the pipeline to show any stray frame, then report.
        settle();
        repeat (20) @(negedge clk);
        if (sb.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
